// File: hdl/ptab_pkg.sv
`default_nettype none

package ptab_pkg;

	// Channel and palette sizing
	localparam int NUM_CHAN = 3;
	localparam int CHAN_W = 8;
	localparam int RGB_W = NUM_CHAN * CHAN_W;
	localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

	// Datapath widths: sum of three 8x8 products, quotient up to 765,
	// final blend sum up to 1020
	localparam int PROD_W = 2 * CHAN_W;
	localparam int SUM_W = 18;
	localparam int TINT_W = 10;
	localparam int OUT_SUM_W = TINT_W + 1;

	// Pipeline depth, input register through output register
	localparam int NUM_STAGES = 7;

	// Configuration register map
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOUR_ONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLOUR_TWO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOUR_THREE = 2'd2;

	typedef logic [NUM_CHAN-1:0][CHAN_W-1:0] rgb_t;

	// Per-stage load enables from the handshake control
	typedef struct packed {
		logic [NUM_STAGES-1:0] en;
	} ptab_pipe_t;

	// Hand-off from the tint section to the blend section
	typedef struct packed {
		logic [NUM_CHAN-1:0][TINT_W-1:0] tint;
		logic [NUM_CHAN-1:0][TINT_W-1:0] ea;
		logic [CHAN_W-1:0] inv_alpha;
		logic present;
	} ptab_mid_t;

	// x/255 estimate: x*257 >> 16, equal to the quotient or one short
	function automatic logic [TINT_W-1:0] div255_est(input logic [SUM_W-1:0] x);
		logic [SUM_W+7:0] t;
		t = {x, 8'b0} + {8'b0, x};
		return t[SUM_W+7:16];
	endfunction

	// Correct the estimate: one step up if the remainder reaches 255
	function automatic logic [TINT_W-1:0] div255_fix(input logic [SUM_W-1:0] x,
			input logic [TINT_W-1:0] q);
		logic [SUM_W-1:0] qm;
		logic [SUM_W-1:0] r;
		qm = {q, 8'b0} - {8'b0, q};
		r = x - qm;
		if (r >= SUM_W'(CHAN_MAX)) begin
			return q + TINT_W'(1);
		end
		return q;
	endfunction

endpackage

`default_nettype wire

// File: hdl/ptab_ctrl.sv
`default_nettype none

module ptab_ctrl
	import ptab_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	output ptab_pipe_t      pipe
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] rdy;

	// A stage may load when empty or when the stage after it moves
	always_comb begin
		rdy[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	// Valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready = rdy[0];
	assign out_valid = vld_q[NUM_STAGES-1];
	assign pipe.en = rdy;

endmodule

`default_nettype wire

// File: hdl/ptab_tint.sv
`default_nettype none

module ptab_tint
	import ptab_pkg::*;
(
	input  wire logic        clk,
	input  wire ptab_pipe_t  pipe,
	input  wire rgb_t        base,
	input  wire rgb_t        emblem,
	input  wire logic [7:0]  alpha,
	input  wire logic        present,
	input  wire rgb_t        col_one,
	input  wire rgb_t        col_two,
	input  wire rgb_t        col_three,
	output ptab_mid_t        mid
);

	// Inverse base channels; base[0] red, [1] green, [2] blue
	logic [CHAN_W-1:0] inv_r, inv_g, inv_b;

	logic [NUM_CHAN-1:0][PROD_W-1:0] prod_a_s1, prod_b_s1, prod_c_s1, ea_prod_s1;
	logic [CHAN_W-1:0] inv_alpha_s1;
	logic present_s1;

	logic [NUM_CHAN-1:0][SUM_W-1:0] sum_s2;
	logic [NUM_CHAN-1:0][PROD_W-1:0] ea_prod_s2;
	logic [CHAN_W-1:0] inv_alpha_s2;
	logic present_s2;

	logic [NUM_CHAN-1:0][SUM_W-1:0] sum_s3;
	logic [NUM_CHAN-1:0][TINT_W-1:0] tint_est_s3;
	logic [NUM_CHAN-1:0][PROD_W-1:0] ea_prod_s3;
	logic [NUM_CHAN-1:0][TINT_W-1:0] ea_est_s3;
	logic [CHAN_W-1:0] inv_alpha_s3;
	logic present_s3;

	ptab_mid_t mid_s4;

	assign inv_r = CHAN_MAX - base[0];
	assign inv_g = CHAN_MAX - base[1];
	assign inv_b = CHAN_MAX - base[2];

	// S1: palette products and emblem*alpha
	always_ff @(posedge clk) begin
		if (pipe.en[0]) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				prod_a_s1[c] <= inv_g * col_one[c];
				prod_b_s1[c] <= inv_r * col_two[c];
				prod_c_s1[c] <= inv_b * col_three[c];
				ea_prod_s1[c] <= emblem[c] * alpha;
			end
			inv_alpha_s1 <= CHAN_MAX - alpha;
			present_s1 <= present;
		end
	end

	// S2: weighted sum
	always_ff @(posedge clk) begin
		if (pipe.en[1]) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				sum_s2[c] <= SUM_W'(prod_a_s1[c]) + SUM_W'(prod_b_s1[c])
					+ SUM_W'(prod_c_s1[c]);
			end
			ea_prod_s2 <= ea_prod_s1;
			inv_alpha_s2 <= inv_alpha_s1;
			present_s2 <= present_s1;
		end
	end

	// S3: reciprocal estimate of /255
	always_ff @(posedge clk) begin
		if (pipe.en[2]) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				tint_est_s3[c] <= div255_est(sum_s2[c]);
				ea_est_s3[c] <= div255_est(SUM_W'(ea_prod_s2[c]));
			end
			sum_s3 <= sum_s2;
			ea_prod_s3 <= ea_prod_s2;
			inv_alpha_s3 <= inv_alpha_s2;
			present_s3 <= present_s2;
		end
	end

	// S4: remainder correction gives exact truncated quotients
	always_ff @(posedge clk) begin
		if (pipe.en[3]) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				mid_s4.tint[c] <= div255_fix(sum_s3[c], tint_est_s3[c]);
				mid_s4.ea[c] <= div255_fix(SUM_W'(ea_prod_s3[c]), ea_est_s3[c]);
			end
			mid_s4.inv_alpha <= inv_alpha_s3;
			mid_s4.present <= present_s3;
		end
	end

	assign mid = mid_s4;

endmodule

`default_nettype wire

// File: hdl/ptab_blend.sv
`default_nettype none

module ptab_blend
	import ptab_pkg::*;
(
	input  wire logic        clk,
	input  wire ptab_pipe_t  pipe,
	input  wire ptab_mid_t   mid,
	output rgb_t             pix
);

	logic [NUM_CHAN-1:0][SUM_W-1:0] bl_prod_s5;
	logic [NUM_CHAN-1:0][TINT_W-1:0] tint_s5, ea_s5;
	logic present_s5;

	logic [NUM_CHAN-1:0][SUM_W-1:0] bl_prod_s6;
	logic [NUM_CHAN-1:0][TINT_W-1:0] bl_est_s6, tint_s6, ea_s6;
	logic present_s6;

	logic [NUM_CHAN-1:0][OUT_SUM_W-1:0] total;
	rgb_t pix_s7;

	// S5: tinted * (255 - alpha)
	always_ff @(posedge clk) begin
		if (pipe.en[4]) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				bl_prod_s5[c] <= SUM_W'(mid.tint[c] * mid.inv_alpha);
			end
			tint_s5 <= mid.tint;
			ea_s5 <= mid.ea;
			present_s5 <= mid.present;
		end
	end

	// S6: reciprocal estimate of /255
	always_ff @(posedge clk) begin
		if (pipe.en[5]) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				bl_est_s6[c] <= div255_est(bl_prod_s5[c]);
			end
			bl_prod_s6 <= bl_prod_s5;
			tint_s6 <= tint_s5;
			ea_s6 <= ea_s5;
			present_s6 <= present_s5;
		end
	end

	// Correct, add emblem term or pass tint through
	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			if (present_s6) begin
				total[c] = OUT_SUM_W'(ea_s6[c])
					+ OUT_SUM_W'(div255_fix(bl_prod_s6[c], bl_est_s6[c]));
			end else begin
				total[c] = OUT_SUM_W'(tint_s6[c]);
			end
		end
	end

	// S7: saturate into the output register
	always_ff @(posedge clk) begin
		if (pipe.en[6]) begin
			for (int c = 0; c < NUM_CHAN; c++) begin
				pix_s7[c] <= (total[c] > OUT_SUM_W'(CHAN_MAX)) ? CHAN_MAX
					: total[c][CHAN_W-1:0];
			end
		end
	end

	assign pix = pix_s7;

endmodule

`default_nettype wire

// File: hdl/palette_tint_alpha_blend_core.sv
// Palette tint and alpha blend, one pixel per word. The three inverted base
// channels weight three palette colours, the weighted sum is divided by 255,
// and where an emblem pixel is present it is laid over the tinted value with
// its alpha; each output channel saturates at 255. A seven-stage pipeline
// accepts one pixel every clock while out_ready is high; every
// division by 255 is a reciprocal estimate in one stage and a remainder
// correction in the next. When out_ready is low, words collect in the empty
// stages ahead of the output register before in_ready drops. Palette writes
// are always accepted (cfg_ready stays high) and are meant for times when
// no pixel is in flight; indexes past the third register are ignored.

`default_nettype none

module palette_tint_alpha_blend_core
	import ptab_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [RGB_W-1:0]     cfg_data,

	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [7:0]           base_red,
	input  wire logic [7:0]           base_green,
	input  wire logic [7:0]           base_blue,
	input  wire logic [7:0]           emblem_red,
	input  wire logic [7:0]           emblem_green,
	input  wire logic [7:0]           emblem_blue,
	input  wire logic [7:0]           emblem_alpha,
	input  wire logic                 emblem_present,

	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [7:0]                out_red,
	output logic [7:0]                out_green,
	output logic [7:0]                out_blue
);

	logic [RGB_W-1:0] colour_one_q, colour_two_q, colour_three_q;
	rgb_t col_one, col_two, col_three;
	rgb_t base, emblem, pix;
	ptab_pipe_t pipe;
	ptab_mid_t mid;

	// Palette registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_one_q <= '0;
			colour_two_q <= '0;
			colour_three_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_COLOUR_ONE:   colour_one_q <= cfg_data;
				REG_COLOUR_TWO:   colour_two_q <= cfg_data;
				REG_COLOUR_THREE: colour_three_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// Channel lanes: [0] red, [1] green, [2] blue
	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			col_one[c] = colour_one_q[(NUM_CHAN-1-c)*CHAN_W +: CHAN_W];
			col_two[c] = colour_two_q[(NUM_CHAN-1-c)*CHAN_W +: CHAN_W];
			col_three[c] = colour_three_q[(NUM_CHAN-1-c)*CHAN_W +: CHAN_W];
		end
	end

	assign base[0] = base_red;
	assign base[1] = base_green;
	assign base[2] = base_blue;
	assign emblem[0] = emblem_red;
	assign emblem[1] = emblem_green;
	assign emblem[2] = emblem_blue;

	ptab_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pipe      (pipe)
	);

	ptab_tint u_tint (
		.clk       (clk),
		.pipe      (pipe),
		.base      (base),
		.emblem    (emblem),
		.alpha     (emblem_alpha),
		.present   (emblem_present),
		.col_one   (col_one),
		.col_two   (col_two),
		.col_three (col_three),
		.mid       (mid)
	);

	ptab_blend u_blend (
		.clk  (clk),
		.pipe (pipe),
		.mid  (mid),
		.pix  (pix)
	);

	assign out_red = pix[0];
	assign out_green = pix[1];
	assign out_blue = pix[2];

endmodule

`default_nettype wire

// File: hdl/ptab_checker.sv
`default_nettype none

module ptab_checker (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic                 in_ready,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire logic [7:0]           out_red,
	input  wire logic [7:0]           out_green,
	input  wire logic [7:0]           out_blue
);

	// An output that is empty or draining frees every stage back to the input
	a_ready_chain: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while output side moves");

	// Palette writes never wait
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("palette write stalled");

	// A stalled output word stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=>
		($stable(out_red) && $stable(out_green) && $stable(out_blue)))
		else $error("output word changed while stalled");

endmodule

bind palette_tint_alpha_blend_core ptab_checker u_ptab_checker (.*);

`default_nettype wire
